@@ hw/rtl/duration_ratio_divider_top_defines.svh @@
// Assertion macros used by the duration ratio divider checker.
`ifndef DURATION_RATIO_DIVIDER_TOP_DEFINES_SVH
`define DURATION_RATIO_DIVIDER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define DRD_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("duration ratio divider check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define DRD_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("duration ratio divider check failed");

`endif

@@ hw/rtl/drd_pkg.sv @@
// Types, constants and the divide step shared by the duration ratio divider.
`default_nettype none
package drd_pkg;

  localparam int unsigned SEC_W        = 32;
  localparam int unsigned NS_W         = 30;
  localparam int unsigned Q_W          = 62;
  localparam int unsigned DV_W         = 32;
  localparam int unsigned PROD_W       = 2 * NS_W;
  localparam int unsigned P1_STEPS     = DV_W;
  localparam int unsigned P2_STEPS     = PROD_W;
  localparam int unsigned FIFO_DEPTH   = 2;
  localparam int unsigned MAX_INFLIGHT = 1 + FIFO_DEPTH + P1_STEPS + 1 + P2_STEPS + 1;

  localparam logic [NS_W-1:0] NANOS_PER_SEC = 30'd1000000000;

  typedef enum logic [1:0] {
    KIND_ZERO,
    KIND_DIRECT,
    KIND_MIXED
  } kind_t;

  typedef struct packed {
    kind_t            kind;
    logic             dz;
    logic [DV_W-1:0]  num;
    logic [NS_W-1:0]  nanos;
    logic [DV_W-1:0]  dv;
  } job_t;

  typedef struct packed {
    kind_t            kind;
    logic             dz;
    logic [DV_W-1:0]  dv;
  } tag1_t;

  typedef struct packed {
    logic             mix;
    logic             dz;
    logic [Q_W-1:0]   res;
    logic [DV_W-1:0]  dv;
  } tag2_t;

  typedef struct packed {
    logic             q;
    logic [DV_W-1:0]  rem;
  } step_t;

  // One restoring step: shift in a dividend bit, subtract when it fits.
  function automatic step_t div_step(logic [DV_W-1:0] rem, logic in_bit,
                                     logic [DV_W-1:0] dv);
    logic [DV_W:0] t;
    step_t         r;
    t = {rem, in_bit};
    if (t >= {1'b0, dv}) begin
      r.q   = 1'b1;
      r.rem = t[DV_W-1:0] - dv;
    end else begin
      r.q   = 1'b0;
      r.rem = t[DV_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/drd_ifs.sv @@
// Valid/ready channel interfaces for the duration ratio divider.
`default_nettype none
interface drd_in_if;
  logic                          valid;
  logic                          ready;
  logic [drd_pkg::SEC_W-1:0]     left_seconds;
  logic [drd_pkg::NS_W-1:0]      left_nanos;
  logic [drd_pkg::SEC_W-1:0]     right_seconds;
  logic [drd_pkg::NS_W-1:0]      right_nanos;

  modport source (output valid, left_seconds, left_nanos, right_seconds, right_nanos,
                  input ready);
  modport sink (input valid, left_seconds, left_nanos, right_seconds, right_nanos,
                output ready);
endinterface

interface drd_out_if;
  logic                      valid;
  logic                      ready;
  logic [drd_pkg::Q_W-1:0]   quotient;
  logic                      divide_by_zero;

  modport source (output valid, quotient, divide_by_zero, input ready);
  modport sink (input valid, quotient, divide_by_zero, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/drd_front.sv @@
// Front end: accepts a request, picks its case and registers the job.
`default_nettype none
module drd_front (
  input  logic           clk,
  input  logic           rst_n,
  drd_in_if.sink         in_s,
  output logic           job_valid,
  output drd_pkg::job_t  job,
  input  logic           job_ready
);

  logic          v_r, v_nxt;
  drd_pkg::job_t job_r, job_nxt;
  logic          ls0, rs0, rn0;

  assign in_s.ready = !v_r || job_ready;
  assign job_valid  = v_r;
  assign job        = job_r;

  assign ls0 = (in_s.left_seconds == '0);
  assign rs0 = (in_s.right_seconds == '0);
  assign rn0 = (in_s.right_nanos == '0);

  always_comb begin
    job_nxt.kind  = drd_pkg::KIND_ZERO;
    job_nxt.dz    = 1'b0;
    job_nxt.num   = '0;
    job_nxt.nanos = in_s.left_nanos;
    job_nxt.dv    = '0;
    if (ls0 && rs0) begin
      if (rn0) begin
        job_nxt.dz = 1'b1;
      end else begin
        job_nxt.kind = drd_pkg::KIND_DIRECT;
        job_nxt.num  = {{(drd_pkg::DV_W-drd_pkg::NS_W){1'b0}}, in_s.left_nanos};
        job_nxt.dv   = {{(drd_pkg::DV_W-drd_pkg::NS_W){1'b0}}, in_s.right_nanos};
      end
    end else if (ls0) begin
      // smaller over bigger: ratio is zero
      job_nxt.kind = drd_pkg::KIND_ZERO;
    end else if (rs0) begin
      if (rn0) begin
        job_nxt.dz = 1'b1;
      end else begin
        job_nxt.kind = drd_pkg::KIND_MIXED;
        job_nxt.num  = in_s.left_seconds;
        job_nxt.dv   = {{(drd_pkg::DV_W-drd_pkg::NS_W){1'b0}}, in_s.right_nanos};
      end
    end else begin
      job_nxt.kind = drd_pkg::KIND_DIRECT;
      job_nxt.num  = in_s.left_seconds;
      job_nxt.dv   = in_s.right_seconds;
    end
  end

  always_comb begin
    v_nxt = in_s.ready ? in_s.valid : v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_s.valid && in_s.ready) begin
      job_r <= job_nxt;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/drd_queue.sv @@
// Short job queue between the front end and the divider pipeline.
`default_nettype none
module drd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  input  drd_pkg::job_t  push_job,
  output logic           push_ready,
  output logic           pop_valid,
  output drd_pkg::job_t  pop_job,
  input  logic           pop_ready
);

  drd_pkg::job_t                                 mem_r [drd_pkg::FIFO_DEPTH];
  logic [$clog2(drd_pkg::FIFO_DEPTH)-1:0]        wp_r, wp_nxt, rp_r, rp_nxt;
  logic [$clog2(drd_pkg::FIFO_DEPTH+1)-1:0]      cnt_r, cnt_nxt;
  logic                                          do_push, do_pop;

  assign push_ready = int'(cnt_r) < drd_pkg::FIFO_DEPTH;
  assign pop_valid  = (cnt_r != '0);
  assign pop_job    = mem_r[rp_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt = (int'(wp_r) == drd_pkg::FIFO_DEPTH - 1) ? '0 : wp_r + 1'b1;
    end
    if (do_pop) begin
      rp_nxt = (int'(rp_r) == drd_pkg::FIFO_DEPTH - 1) ? '0 : rp_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= push_job;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/drd_back.sv @@
// Back end: divider pipelines, cross products and the result register.
`default_nettype none
module drd_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           job_valid,
  input  drd_pkg::job_t  job,
  output logic           job_ready,
  drd_out_if.source      out_s
);

  localparam int unsigned P1 = drd_pkg::P1_STEPS;
  localparam int unsigned P2 = drd_pkg::P2_STEPS;

  logic en;

  // phase one: three restoring lanes sharing one divisor
  logic                      v1_r  [1:P1];
  logic [drd_pkg::DV_W-1:0]  xr_r  [1:P1];
  logic [drd_pkg::DV_W-1:0]  xq_r  [1:P1];
  logic [drd_pkg::DV_W-1:0]  yr_r  [1:P1];
  logic [drd_pkg::DV_W-1:0]  yq_r  [1:P1];
  logic [drd_pkg::DV_W-1:0]  zr_r  [1:P1];
  logic [drd_pkg::DV_W-1:0]  zq_r  [1:P1];
  drd_pkg::tag1_t            t1_r  [1:P1];

  // product stage
  logic                       vm_r;
  logic [drd_pkg::PROD_W-1:0] prod_r;
  logic [drd_pkg::Q_W-1:0]    p1m_r;
  logic [drd_pkg::PROD_W-1:0] p2m_r;
  logic [drd_pkg::NS_W-1:0]   qz_r;
  logic [drd_pkg::DV_W-1:0]   qx_r;
  drd_pkg::tag1_t             tm_r;
  drd_pkg::tag2_t             t2_head;
  logic [drd_pkg::Q_W-1:0]    base;

  // phase two: cross term divided by the nanoseconds divisor
  logic                       v2_r  [1:P2];
  logic [drd_pkg::DV_W-1:0]   rr_r  [1:P2];
  logic [drd_pkg::PROD_W-1:0] dq_r  [1:P2];
  drd_pkg::tag2_t             t2_r  [1:P2];

  logic                       ov_r;
  logic [drd_pkg::Q_W-1:0]    oq_r;
  logic                       odz_r;

  // advance the whole pipeline when the result register can take a request
  assign en        = !ov_r || out_s.ready;
  assign job_ready = en;

  for (genvar k = 1; k <= P1; k++) begin : g_p1
    logic                     cv;
    logic [drd_pkg::DV_W-1:0] cxr, cxq, cyr, cyq, czr, czq;
    drd_pkg::tag1_t           ct;
    drd_pkg::step_t           sx, sy, sz;

    if (k == 1) begin : g_head
      assign cv      = job_valid;
      assign cxr     = '0;
      assign cxq     = job.num;
      assign cyr     = '0;
      assign cyq     = {{(drd_pkg::DV_W-drd_pkg::NS_W){1'b0}}, drd_pkg::NANOS_PER_SEC};
      assign czr     = '0;
      assign czq     = {{(drd_pkg::DV_W-drd_pkg::NS_W){1'b0}}, job.nanos};
      assign ct.kind = job.kind;
      assign ct.dz   = job.dz;
      assign ct.dv   = job.dv;
    end else begin : g_mid
      assign cv  = v1_r[k-1];
      assign cxr = xr_r[k-1];
      assign cxq = xq_r[k-1];
      assign cyr = yr_r[k-1];
      assign cyq = yq_r[k-1];
      assign czr = zr_r[k-1];
      assign czq = zq_r[k-1];
      assign ct  = t1_r[k-1];
    end

    assign sx = drd_pkg::div_step(cxr, cxq[drd_pkg::DV_W-1], ct.dv);
    assign sy = drd_pkg::div_step(cyr, cyq[drd_pkg::DV_W-1], ct.dv);
    assign sz = drd_pkg::div_step(czr, czq[drd_pkg::DV_W-1], ct.dv);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v1_r[k] <= 1'b0;
      end else if (en) begin
        v1_r[k] <= cv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        xr_r[k] <= sx.rem;
        xq_r[k] <= {cxq[drd_pkg::DV_W-2:0], sx.q};
        yr_r[k] <= sy.rem;
        yq_r[k] <= {cyq[drd_pkg::DV_W-2:0], sy.q};
        zr_r[k] <= sz.rem;
        zq_r[k] <= {czq[drd_pkg::DV_W-2:0], sz.q};
        t1_r[k] <= ct;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm_r <= 1'b0;
    end else if (en) begin
      vm_r <= v1_r[P1];
    end
  end

  // ar*br, aq*B and Bq*ar; the remainders stay below the 30-bit divisor
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= drd_pkg::PROD_W'(xr_r[P1][drd_pkg::NS_W-1:0])
              * drd_pkg::PROD_W'(yr_r[P1][drd_pkg::NS_W-1:0]);
      p1m_r  <= drd_pkg::Q_W'(xq_r[P1]) * drd_pkg::Q_W'(drd_pkg::NANOS_PER_SEC);
      p2m_r  <= drd_pkg::PROD_W'(yq_r[P1][drd_pkg::NS_W-1:0])
              * drd_pkg::PROD_W'(xr_r[P1][drd_pkg::NS_W-1:0]);
      qz_r   <= zq_r[P1][drd_pkg::NS_W-1:0];
      qx_r   <= xq_r[P1];
      tm_r   <= t1_r[P1];
    end
  end

  assign base = p1m_r
              + {{(drd_pkg::Q_W-drd_pkg::PROD_W){1'b0}}, p2m_r}
              + {{(drd_pkg::Q_W-drd_pkg::NS_W){1'b0}}, qz_r};

  always_comb begin
    t2_head.mix = (tm_r.kind == drd_pkg::KIND_MIXED);
    t2_head.dz  = tm_r.dz;
    t2_head.dv  = tm_r.dv;
    unique case (tm_r.kind)
      drd_pkg::KIND_ZERO:   t2_head.res = '0;
      drd_pkg::KIND_DIRECT: t2_head.res = {{(drd_pkg::Q_W-drd_pkg::DV_W){1'b0}}, qx_r};
      drd_pkg::KIND_MIXED:  t2_head.res = base;
      default:              t2_head.res = '0;
    endcase
  end

  for (genvar k = 1; k <= P2; k++) begin : g_p2
    logic                       cv;
    logic [drd_pkg::DV_W-1:0]   crem;
    logic [drd_pkg::PROD_W-1:0] cdq;
    drd_pkg::tag2_t             ct;
    drd_pkg::step_t             s;

    if (k == 1) begin : g_head
      assign cv   = vm_r;
      assign crem = '0;
      assign cdq  = prod_r;
      assign ct   = t2_head;
    end else begin : g_mid
      assign cv   = v2_r[k-1];
      assign crem = rr_r[k-1];
      assign cdq  = dq_r[k-1];
      assign ct   = t2_r[k-1];
    end

    assign s = drd_pkg::div_step(crem, cdq[drd_pkg::PROD_W-1], ct.dv);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v2_r[k] <= 1'b0;
      end else if (en) begin
        v2_r[k] <= cv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rr_r[k] <= s.rem;
        dq_r[k] <= {cdq[drd_pkg::PROD_W-2:0], s.q};
        t2_r[k] <= ct;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (en) begin
      ov_r <= v2_r[P2];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      oq_r  <= t2_r[P2].mix
             ? t2_r[P2].res + {{(drd_pkg::Q_W-drd_pkg::PROD_W){1'b0}}, dq_r[P2]}
             : t2_r[P2].res;
      odz_r <= t2_r[P2].dz;
    end
  end

  assign out_s.valid          = ov_r;
  assign out_s.quotient       = oq_r;
  assign out_s.divide_by_zero = odz_r;

endmodule
`default_nettype wire

@@ hw/rtl/duration_ratio_divider_top.sv @@
// Top level of the duration ratio divider.
//
//   channel  dir  fields                                          handshake
//   in_s     in   left_seconds left_nanos right_seconds right_nanos valid/ready
//   out_s    out  quotient divide_by_zero                          valid/ready
//
// One request per cycle sustained while out_s is ready; each passes from acceptance
// to result through the 32-step and 60-step restoring divider pipelines.
// rst_n is synchronous and empties every stage and the queue.
// A stalled result freezes the divider pipeline; the front register and the
// two-entry queue keep taking requests until they fill.
`default_nettype none
module duration_ratio_divider_top (
  input  logic       clk,
  input  logic       rst_n,
  drd_in_if.sink     in_s,
  drd_out_if.source  out_s
);

  logic          f_valid, f_ready;
  drd_pkg::job_t f_job;
  logic          b_valid, b_ready;
  drd_pkg::job_t b_job;

  drd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_s      (in_s),
    .job_valid (f_valid),
    .job       (f_job),
    .job_ready (f_ready)
  );

  drd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_job   (f_job),
    .push_ready (f_ready),
    .pop_valid  (b_valid),
    .pop_job    (b_job),
    .pop_ready  (b_ready)
  );

  drd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (b_valid),
    .job       (b_job),
    .job_ready (b_ready),
    .out_s     (out_s)
  );

endmodule
`default_nettype wire

@@ hw/rtl/drd_checker.sv @@
// Port-level checks for the duration ratio divider, bound to the top level.
`default_nettype none
`include "duration_ratio_divider_top_defines.svh"
module drd_checker (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic [drd_pkg::Q_W-1:0]  out_quotient,
  input  logic                     out_dz
);

  logic [$clog2(drd_pkg::MAX_INFLIGHT+1)-1:0] cnt_r, cnt_nxt;
  logic                                       in_acc, out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // track requests accepted but not yet delivered
  always_comb begin
    cnt_nxt = cnt_r;
    if (in_acc && !out_acc) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (out_acc && !in_acc) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  `DRD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                   out_valid && $stable(out_quotient) && $stable(out_dz))
  `DRD_ASSERT_IMPL(a_dz_zero, out_valid && out_dz, out_quotient == '0)
  `DRD_ASSERT_IMPL(a_no_orphan, out_valid, cnt_r != '0)
  `DRD_ASSERT_IMPL(a_inflight_bound, 1'b1, int'(cnt_r) <= drd_pkg::MAX_INFLIGHT)

endmodule

bind duration_ratio_divider_top drd_checker u_drd_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_s.valid),
  .in_ready     (in_s.ready),
  .out_valid    (out_s.valid),
  .out_ready    (out_s.ready),
  .out_quotient (out_s.quotient),
  .out_dz       (out_s.divide_by_zero)
);
`default_nettype wire
